>>> hw/rtl/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg: shared types and constants of the RGB to YUV format converter
// Holds the output mode codes, the per-pixel luma/chroma record and the
// control record that travels down the pipeline beside the pixel data.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

	localparam int PIX_W     = 32;
	localparam int NUM_LANES = 4;

	// Output format codes as written into the mode register.
	typedef enum logic [2:0] {
		MODE_RGB32 = 3'd0,
		MODE_RGB24 = 3'd1,
		MODE_RGB16 = 3'd2,
		MODE_RGB15 = 3'd3,
		MODE_UYVY  = 3'd4,
		MODE_YUY2  = 3'd5,
		MODE_YV12  = 3'd6,
		MODE_I420  = 3'd7
	} mode_t;

	// BT.601 values of one pixel.
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} yuv_t;

	// Control that follows one transaction through the pipeline.
	typedef struct packed {
		logic  valid;
		mode_t mode;
	} ctl_t;

endpackage

>>> hw/rtl/rgb2yuv_lane.sv
// ----------------------------------------------------------------------------
// rgb2yuv_lane: per-pixel BT.601 core
// Quantizes one XRGB8888 pixel to RGB565, expands it back to 8 bits per
// channel and computes Y, U and V in thousandths over three register stages.
// ----------------------------------------------------------------------------
module rgb2yuv_lane import rgb2yuv_pkg::*; (
	input  logic             clk,
	input  logic [PIX_W-1:0] pixel,
	output yuv_t             yuv_s3
);

	localparam int IDX_Y = 0;
	localparam int IDX_U = 1;
	localparam int IDX_V = 2;

	localparam logic signed [19:0] Y_CR  = 20'sd257;
	localparam logic signed [19:0] Y_CG  = 20'sd504;
	localparam logic signed [19:0] Y_CB  = 20'sd98;
	localparam logic signed [19:0] Y_OFS = 20'sd16000;
	localparam logic signed [19:0] U_CR  = 20'sd148;
	localparam logic signed [19:0] U_CG  = 20'sd291;
	localparam logic signed [19:0] U_CB  = 20'sd439;
	localparam logic signed [19:0] V_CR  = 20'sd439;
	localparam logic signed [19:0] V_CG  = 20'sd368;
	localparam logic signed [19:0] V_CB  = 20'sd71;
	localparam logic signed [19:0] C_OFS = 20'sd128000;
	// Any numerator at or above this value saturates to 255.
	localparam logic signed [19:0] SAT_NUM = 20'sd256000;
	// ceil(2^28 / 1000): exact quotient by 1000 for numerators below 2^18.
	localparam logic [18:0] RECIP = 19'd268436;
	localparam int          RSH   = 28;

	logic [7:0] r8, g8, b8;
	logic signed [19:0] rs, gs, bs;
	logic signed [19:0] num_c [3];

	logic signed [19:0] num_s1 [3];
	logic [36:0]        prod_s2 [3];
	logic [2:0]         neg_s2, sat_s2;
	logic [7:0]         q_c [3];

	always_comb begin
		r8 = {pixel[23:19], pixel[23:21]};
		g8 = {pixel[15:10], pixel[15:14]};
		b8 = {pixel[7:3], pixel[7:5]};
		rs = $signed({12'b0, r8});
		gs = $signed({12'b0, g8});
		bs = $signed({12'b0, b8});
		num_c[IDX_Y] = Y_OFS + Y_CR * rs + Y_CG * gs + Y_CB * bs;
		num_c[IDX_U] = C_OFS + U_CB * bs - U_CR * rs - U_CG * gs;
		num_c[IDX_V] = C_OFS + V_CR * rs - V_CG * gs - V_CB * bs;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			num_s1[k]  <= num_c[k];
			prod_s2[k] <= num_s1[k][17:0] * RECIP;
			neg_s2[k]  <= num_s1[k][19];
			sat_s2[k]  <= (num_s1[k] >= SAT_NUM);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (neg_s2[k]) begin
				q_c[k] = 8'd0;
			end else if (sat_s2[k]) begin
				q_c[k] = 8'd255;
			end else begin
				q_c[k] = prod_s2[k][RSH+7:RSH];
			end
		end
	end

	always_ff @(posedge clk) begin
		yuv_s3.y <= q_c[IDX_Y];
		yuv_s3.u <= q_c[IDX_U];
		yuv_s3.v <= q_c[IDX_V];
	end

endmodule

>>> hw/rtl/rgb2yuv_merge.sv
// ----------------------------------------------------------------------------
// rgb2yuv_merge: chroma averaging and output formatting
// Combines the lane results into the packed or planar YUV words, or repacks
// the raw pixels in RGB modes, and registers the result.
// ----------------------------------------------------------------------------
module rgb2yuv_merge import rgb2yuv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl_s3,
	input  logic [PIX_W-1:0] pix_a_s3,
	input  logic [PIX_W-1:0] pix_b_s3,
	input  yuv_t             yuv_s3 [NUM_LANES],
	output logic             strobe_s4,
	output logic [PIX_W-1:0] word_first_s4,
	output logic [PIX_W-1:0] word_second_s4,
	output logic [7:0]       chroma_u_s4,
	output logic [7:0]       chroma_v_s4
);

	logic [8:0]       u_pair, v_pair;
	logic [9:0]       u_quad, v_quad;
	logic [PIX_W-1:0] w0_c, w1_c;
	logic [7:0]       cu_c, cv_c;

	always_comb begin
		u_pair = {1'b0, yuv_s3[0].u} + {1'b0, yuv_s3[1].u};
		v_pair = {1'b0, yuv_s3[0].v} + {1'b0, yuv_s3[1].v};
		u_quad = {2'b0, yuv_s3[0].u} + {2'b0, yuv_s3[1].u}
			+ {2'b0, yuv_s3[2].u} + {2'b0, yuv_s3[3].u};
		v_quad = {2'b0, yuv_s3[0].v} + {2'b0, yuv_s3[1].v}
			+ {2'b0, yuv_s3[2].v} + {2'b0, yuv_s3[3].v};
		cu_c = 8'd0;
		cv_c = 8'd0;
		case (ctl_s3.mode)
			MODE_RGB32: begin
				w0_c = pix_a_s3;
				w1_c = pix_b_s3;
			end
			MODE_RGB24: begin
				w0_c = {8'b0, pix_a_s3[23:0]};
				w1_c = {8'b0, pix_b_s3[23:0]};
			end
			MODE_RGB16: begin
				w0_c = {16'b0, pix_a_s3[23:19], pix_a_s3[15:10], pix_a_s3[7:3]};
				w1_c = {16'b0, pix_b_s3[23:19], pix_b_s3[15:10], pix_b_s3[7:3]};
			end
			MODE_RGB15: begin
				w0_c = {17'b0, pix_a_s3[23:19], pix_a_s3[15:11], pix_a_s3[7:3]};
				w1_c = {17'b0, pix_b_s3[23:19], pix_b_s3[15:11], pix_b_s3[7:3]};
			end
			MODE_UYVY: begin
				w0_c = {16'b0, yuv_s3[0].y, u_pair[8:1]};
				w1_c = {16'b0, yuv_s3[1].y, v_pair[8:1]};
			end
			MODE_YUY2: begin
				w0_c = {16'b0, u_pair[8:1], yuv_s3[0].y};
				w1_c = {16'b0, v_pair[8:1], yuv_s3[1].y};
			end
			MODE_YV12, MODE_I420: begin
				w0_c = {16'b0, yuv_s3[1].y, yuv_s3[0].y};
				w1_c = {16'b0, yuv_s3[3].y, yuv_s3[2].y};
				cu_c = u_quad[9:2];
				cv_c = v_quad[9:2];
			end
			default: begin
				w0_c = pix_a_s3;
				w1_c = pix_b_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s4 <= 1'b0;
		end else begin
			strobe_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		word_first_s4  <= w0_c;
		word_second_s4 <= w1_c;
		chroma_u_s4    <= cu_c;
		chroma_v_s4    <= cv_c;
	end

endmodule

>>> hw/rtl/rgb_to_yuv_format_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv_format_converter: XRGB8888 to RGB/YUV output format converter
// Converts four pixels per transaction into RGB32/24/16/15, packed UYVY or
// YUY2, or planar YV12/I420 data with BT.601 luma and averaged chroma.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on each rising edge with start high and busy
//   low. busy never rises: the block takes a new transaction every cycle.
//   pixel_a and pixel_b are the two pixels of a packed pair; in planar modes
//   pixel_c and pixel_d complete the 2x2 block below them.
//   The result is registered through the lane pipeline and the merge stage
//   and is flagged by strobe for a single cycle. Throughput is one
//   transaction per clock.
//   The latency is set by the lane pipeline (constant multiply and sum,
//   reciprocal multiply for the divide by 1000, clamp) plus the register in
//   the merge stage that averages chroma and packs the words.
//   The receiver has no way to stall; it must take each result as shown.
//   The mode register is written over the cfg channel (cfg_ready is always
//   high); it must only change while no transaction is in flight.
//   arst_n clears the mode to RGB32 and empties the pipeline at once, so no
//   strobe follows reset until a new transaction is started.
// ----------------------------------------------------------------------------
module rgb_to_yuv_format_converter import rgb2yuv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [PIX_W-1:0] pixel_a,
	input  logic [PIX_W-1:0] pixel_b,
	input  logic [PIX_W-1:0] pixel_c,
	input  logic [PIX_W-1:0] pixel_d,
	output logic             strobe,
	output logic [PIX_W-1:0] word_first,
	output logic [PIX_W-1:0] word_second,
	output logic [7:0]       chroma_u,
	output logic [7:0]       chroma_v,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_data
);

	mode_t mode_q;

	ctl_t             ctl_s1, ctl_s2, ctl_s3;
	logic [PIX_W-1:0] pix_a_s1, pix_a_s2, pix_a_s3;
	logic [PIX_W-1:0] pix_b_s1, pix_b_s2, pix_b_s3;
	logic [PIX_W-1:0] lane_pix [NUM_LANES];
	yuv_t             yuv_s3 [NUM_LANES];

	// The pipeline never blocks, so both handshakes are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RGB32;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// The mode is captured with each transaction so it stays with its data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.mode  <= mode_q;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	// Raw pixels for the RGB repacking modes ride beside the lanes.
	always_ff @(posedge clk) begin
		pix_a_s1 <= pixel_a;
		pix_a_s2 <= pix_a_s1;
		pix_a_s3 <= pix_a_s2;
		pix_b_s1 <= pixel_b;
		pix_b_s2 <= pix_b_s1;
		pix_b_s3 <= pix_b_s2;
	end

	assign lane_pix[0] = pixel_a;
	assign lane_pix[1] = pixel_b;
	assign lane_pix[2] = pixel_c;
	assign lane_pix[3] = pixel_d;

	// One BT.601 lane per pixel of the transaction.
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rgb2yuv_lane u_lane (
			.clk    (clk),
			.pixel  (lane_pix[i]),
			.yuv_s3 (yuv_s3[i])
		);
	end

	rgb2yuv_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_s3         (ctl_s3),
		.pix_a_s3       (pix_a_s3),
		.pix_b_s3       (pix_b_s3),
		.yuv_s3         (yuv_s3),
		.strobe_s4      (strobe),
		.word_first_s4  (word_first),
		.word_second_s4 (word_second),
		.chroma_u_s4    (chroma_u),
		.chroma_v_s4    (chroma_v)
	);

endmodule

>>> hw/rtl/rgb2yuv_checker.sv
// ----------------------------------------------------------------------------
// rgb2yuv_checker: port-level checks of the format converter
// Checks the fixed result latency and the shape of planar results.
// ----------------------------------------------------------------------------
module rgb2yuv_checker import rgb2yuv_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             strobe,
	input logic [PIX_W-1:0] word_first,
	input logic [PIX_W-1:0] word_second,
	input logic [7:0]       chroma_u,
	input logic [7:0]       chroma_v
);

	// Every accepted transaction is followed by a strobed result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 strobe)
		else $error("result missing four cycles after acceptance");

	// No result appears without an earlier matching accepted transaction.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 4))
		else $error("result without a matching accepted transaction");

	// Nonzero chroma only comes from planar modes, whose luma words are 16 bits.
	a_planar_u: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && chroma_u != 8'd0) |-> (word_first[31:16] == 16'd0))
		else $error("planar chroma with a wide first word");

	a_planar_v: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && chroma_v != 8'd0) |-> (word_second[31:16] == 16'd0))
		else $error("planar chroma with a wide second word");

endmodule

bind rgb_to_yuv_format_converter rgb2yuv_checker u_rgb2yuv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.strobe      (strobe),
	.word_first  (word_first),
	.word_second (word_second),
	.chroma_u    (chroma_u),
	.chroma_v    (chroma_v)
);

>>> dv/rgb_to_yuv_checker.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv_checker: scoreboard for the RGB to YUV format converter
// Watches the pixel, result and mode channels, predicts each conversion and
// compares every strobed result with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module rgb_to_yuv_checker import rgb2yuv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [PIX_W-1:0] pixel_a,
	input  logic [PIX_W-1:0] pixel_b,
	input  logic [PIX_W-1:0] pixel_c,
	input  logic [PIX_W-1:0] pixel_d,
	input  logic             strobe,
	input  logic [PIX_W-1:0] word_first,
	input  logic [PIX_W-1:0] word_second,
	input  logic [7:0]       chroma_u,
	input  logic [7:0]       chroma_v,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [2:0]       cfg_data,
	output int               fail_count,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] word_first;
		logic [31:0] word_second;
		logic [7:0]  chroma_u;
		logic [7:0]  chroma_v;
	} conversion_t;

	conversion_t conversion_q[$];
	mode_t       mode_shadow;
	int          mismatches = 0;

	function automatic logic [15:0] pack_rgb565(input logic [31:0] p);
		return {p[23:19], p[15:10], p[7:3]};
	endfunction

	function automatic logic [15:0] pack_rgb555(input logic [31:0] p);
		return {1'b0, p[23:19], p[15:11], p[7:3]};
	endfunction

	function automatic logic [7:0] clip_thousandths(input int num);
		if (num < 0)
			return 8'd0;
		if (num / 1000 > 255)
			return 8'hff;
		return 8'(num / 1000);
	endfunction

	// The pixel is cut down to RGB565 and widened again by bit replication
	// before the BT.601 sums, so the low bits of each channel never matter.
	function automatic yuv_t pixel_to_yuv(input logic [31:0] p);
		int   r;
		int   g;
		int   b;
		yuv_t res;
		r = {p[23:19], p[23:21]};
		g = {p[15:10], p[15:14]};
		b = {p[7:3], p[7:5]};
		res.y = clip_thousandths(257 * r + 504 * g + 98 * b + 16000);
		res.u = clip_thousandths(-148 * r - 291 * g + 439 * b + 128000);
		res.v = clip_thousandths(439 * r - 368 * g - 71 * b + 128000);
		return res;
	endfunction

	function automatic conversion_t convert_block(input mode_t m,
			input logic [31:0] pa, input logic [31:0] pb,
			input logic [31:0] pc, input logic [31:0] pd);
		yuv_t        ya;
		yuv_t        yb;
		yuv_t        yc;
		yuv_t        yd;
		logic [7:0]  u_avg;
		logic [7:0]  v_avg;
		conversion_t res;
		res = '{32'd0, 32'd0, 8'd0, 8'd0};
		ya = pixel_to_yuv(pa);
		yb = pixel_to_yuv(pb);
		yc = pixel_to_yuv(pc);
		yd = pixel_to_yuv(pd);
		case (m)
			MODE_RGB32: begin
				res.word_first  = pa;
				res.word_second = pb;
			end
			MODE_RGB24: begin
				res.word_first  = {8'h00, pa[23:0]};
				res.word_second = {8'h00, pb[23:0]};
			end
			MODE_RGB16: begin
				res.word_first  = {16'h0000, pack_rgb565(pa)};
				res.word_second = {16'h0000, pack_rgb565(pb)};
			end
			MODE_RGB15: begin
				res.word_first  = {16'h0000, pack_rgb555(pa)};
				res.word_second = {16'h0000, pack_rgb555(pb)};
			end
			MODE_UYVY, MODE_YUY2: begin
				u_avg = 8'((int'(ya.u) + int'(yb.u)) >> 1);
				v_avg = 8'((int'(ya.v) + int'(yb.v)) >> 1);
				if (m == MODE_UYVY) begin
					res.word_first  = {16'h0000, ya.y, u_avg};
					res.word_second = {16'h0000, yb.y, v_avg};
				end else begin
					res.word_first  = {16'h0000, u_avg, ya.y};
					res.word_second = {16'h0000, v_avg, yb.y};
				end
			end
			default: begin
				res.word_first  = {16'h0000, yb.y, ya.y};
				res.word_second = {16'h0000, yd.y, yc.y};
				res.chroma_u = 8'((int'(ya.u) + int'(yb.u) + int'(yc.u) + int'(yd.u)) >> 2);
				res.chroma_v = 8'((int'(ya.v) + int'(yb.v) + int'(yc.v) + int'(yd.v)) >> 2);
			end
		endcase
		return res;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// A strobe at an edge can never belong to the transaction accepted at
	// that same edge, so results are checked before the new prediction is
	// queued. The mode register updates after the prediction uses it.
	always @(posedge clk or negedge arst_n) begin
		conversion_t want;
		if (!arst_n) begin
			conversion_q.delete();
			mode_shadow <= MODE_RGB32;
			outstanding <= 0;
			fail_count  <= mismatches;
		end else begin
			if (strobe) begin
				if (conversion_q.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %h %h %h %h",
						$time, word_first, word_second, chroma_u, chroma_v);
					mismatches++;
				end else begin
					want = conversion_q.pop_front();
					compare_field("word_first", want.word_first, word_first);
					compare_field("word_second", want.word_second, word_second);
					compare_field("chroma_u", 32'(want.chroma_u), 32'(chroma_u));
					compare_field("chroma_v", 32'(want.chroma_v), 32'(chroma_v));
				end
			end
			if (start && !busy)
				conversion_q.push_back(convert_block(mode_shadow, pixel_a, pixel_b,
					pixel_c, pixel_d));
			if (cfg_valid && cfg_ready)
				mode_shadow <= mode_t'(cfg_data);
			outstanding <= conversion_q.size();
			fail_count  <= mismatches;
		end
	end

endmodule

>>> dv/tb_rgb_to_yuv_format_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv_format_converter: regression for the format converter
// Drives directed and random pixel transactions through every output mode,
// with random gaps or back to back, and lets a checker score each result.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv_format_converter;
	timeunit 1ns;
	timeprecision 1ps;
	import rgb2yuv_pkg::*;

	// Number of random transactions, cycles allowed for the pipeline to
	// empty, and quiet cycles added after it has emptied, which leave the
	// block idle.
	localparam int RANDOM_ITEMS  = 1750;
	localparam int DRAIN_LIMIT   = 200;
	localparam int SETTLE_CYCLES = 8;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [PIX_W-1:0] pixel_a;
	logic [PIX_W-1:0] pixel_b;
	logic [PIX_W-1:0] pixel_c;
	logic [PIX_W-1:0] pixel_d;
	logic             strobe;
	logic [PIX_W-1:0] word_first;
	logic [PIX_W-1:0] word_second;
	logic [7:0]       chroma_u;
	logic [7:0]       chroma_v;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [2:0]       cfg_data;
	int               fail_count;
	int               outstanding;

	// When set, transactions follow each other back to back.
	logic             burst;

	rgb_to_yuv_format_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel_a     (pixel_a),
		.pixel_b     (pixel_b),
		.pixel_c     (pixel_c),
		.pixel_d     (pixel_d),
		.strobe      (strobe),
		.word_first  (word_first),
		.word_second (word_second),
		.chroma_u    (chroma_u),
		.chroma_v    (chroma_v),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	rgb_to_yuv_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel_a     (pixel_a),
		.pixel_b     (pixel_b),
		.pixel_c     (pixel_c),
		.pixel_d     (pixel_d),
		.strobe      (strobe),
		.word_first  (word_first),
		.word_second (word_second),
		.chroma_u    (chroma_u),
		.chroma_v    (chroma_v),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The slowest correct run takes about 100 us. This limit leaves roughly
	// ten times that before the run is declared hung.
	initial begin
		#1ms;
		$display("rgb_to_yuv_format_converter regression: fail");
		$finish;
	end

	// Most pixels are fully random. One in four has some of its bytes forced
	// to all zeros or all ones, which reaches the corners of the color space
	// and the unused top byte far more often than chance would.
	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		p = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int k = 0; k < 4; k++)
				if ($urandom_range(0, 1) == 1)
					p[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
		end
		return p;
	endfunction

	// Offers one transaction and returns right after the edge that accepted
	// it. Before the offer, start drops for a random number of cycles unless
	// a burst is running; the pixel ports carry noise while start is low.
	// Every nonblocking assignment to start lands on its own falling edge.
	task automatic send_pixels(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			start   <= 1'b0;
			pixel_a <= $urandom;
			pixel_b <= $urandom;
			pixel_c <= $urandom;
			pixel_d <= $urandom;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		pixel_a <= a;
		pixel_b <= b;
		pixel_c <= c;
		pixel_d <= d;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Waits, with a bound, until the checker holds no pending prediction, and
	// then for a few quiet cycles. A lost result leaves the count nonzero,
	// which the final verdict catches.
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The mode may only change with the pipeline empty, so start is lowered
	// and every pending result is collected before the write transaction.
	task automatic write_mode(input mode_t m);
		@(negedge clk);
		start <= 1'b0;
		drain_pipeline();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= 3'($urandom);
	endtask

	initial begin
		int sent;
		int phase;
		int phase_len;

		// Every input is known from time zero; reset is released on a falling
		// edge, away from the sampling edge.
		arst_n    = 1'b0;
		start     = 1'b0;
		pixel_a   = '0;
		pixel_b   = '0;
		pixel_c   = '0;
		pixel_d   = '0;
		cfg_valid = 1'b0;
		cfg_data  = MODE_RGB32;
		burst     = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: three blocks in each mode. The first mode is the
		// reset value, so it runs without any register write. The blocks are
		// all zeros, all ones, and pure red, green and blue beside a gray
		// pixel whose top byte is set. The all-ones block shows that the top
		// byte only survives in RGB32, and the last one that the lower pixels
		// only count in the planar modes.
		for (int m = 0; m < 8; m++) begin
			if (m != 0)
				write_mode(mode_t'(m));
			send_pixels(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
			send_pixels(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
			send_pixels(32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'hff80_8080);
		end

		// Random part: phases of random length, each in one mode. The first
		// eight phases walk the modes from I420 down to RGB32 so that both
		// extremes are written; later phases pick a mode at random. About a
		// quarter of the phases run back to back with no gaps at all.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			write_mode((phase < 8) ? mode_t'(7 - phase) : mode_t'($urandom_range(0, 7)));
			burst     = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 120);
			repeat (phase_len) begin
				send_pixels(random_pixel(), random_pixel(), random_pixel(), random_pixel());
				sent++;
			end
			phase++;
		end
		burst = 1'b0;

		@(negedge clk);
		start <= 1'b0;
		drain_pipeline();

		if (fail_count == 0 && outstanding == 0) begin
			$display("rgb_to_yuv_format_converter regression: pass");
		end else begin
			if (outstanding != 0)
				$display("%0t: results never arrived, expected %0d more, actual 0",
					$time, outstanding);
			$display("rgb_to_yuv_format_converter regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/rgb2yuv_pkg.sv
hw/rtl/rgb2yuv_lane.sv
hw/rtl/rgb2yuv_merge.sv
hw/rtl/rgb_to_yuv_format_converter.sv
hw/rtl/rgb2yuv_checker.sv
dv/rgb_to_yuv_checker.sv
dv/tb_rgb_to_yuv_format_converter.sv
